FILE: hdl/pdacc_pkg.sv
package pdacc_pkg;

    localparam int NUM_TEMPLATES = 3;
    localparam int CHANNEL_BITS  = 15;
    localparam int COUNT_BITS    = 24;
    localparam int AMP_BITS      = 48;
    localparam int LN_STEPS      = 60;
    localparam int LN_FRAC       = 60;
    localparam int CFG_ADDR_BITS = 6;
    localparam int CFG_DATA_BITS = 64;
    localparam int DEV_BITS      = 63;
    localparam int SUM_BITS      = 62;

    localparam logic [63:0]         DEV_LIMIT = (64'd1 << SUM_BITS) - 64'd1;
    localparam logic [DEV_BITS-1:0] DEV_FULL  = '1;

    typedef enum logic [1:0] {
        BG_NONE  = 2'd0,
        BG_QUAD  = 2'd1,
        BG_LIN   = 2'd2,
        BG_CONST = 2'd3
    } bg_mode_t;

    typedef enum logic [2:0] {
        REG_BG_MODE  = 3'd0,
        REG_REL_MASK = 3'd1,
        REG_BG_C0    = 3'd2,
        REG_BG_C1    = 3'd3,
        REG_BG_C2    = 3'd4,
        REG_AMP0     = 3'd5,
        REG_AMP1     = 3'd6,
        REG_AMP2     = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] channel;
        logic [COUNT_BITS-1:0]   observed_count;
        logic [COUNT_BITS-1:0]   template_count_0;
        logic [COUNT_BITS-1:0]   template_count_1;
        logic [COUNT_BITS-1:0]   template_count_2;
        logic                    last_channel;
    } in_item_t;

    typedef struct packed {
        logic [DEV_BITS-1:0] deviance;
        logic                model_negative;
        logic                overflowed;
    } out_item_t;

    typedef struct packed {
        bg_mode_t                   background_mode;
        logic [2:0]                 relative_mask;
        logic signed [AMP_BITS-1:0] bg_coeff_0;
        logic signed [AMP_BITS-1:0] bg_coeff_1;
        logic signed [AMP_BITS-1:0] bg_coeff_2;
        logic signed [AMP_BITS-1:0] amplitude_0;
        logic signed [AMP_BITS-1:0] amplitude_1;
        logic signed [AMP_BITS-1:0] amplitude_2;
    } cfg_t;

    typedef enum logic [3:0] {
        OP_NOP, OP_ACC_CLR, OP_MUL, OP_SAVE_REL1, OP_SAVE_REL2, OP_ACC_C0,
        OP_CHECK_Y, OP_LN_LOAD, OP_LN_NORM, OP_LN_MANT, OP_LN_ITER,
        OP_LN_FIN1, OP_LN_FIN2, OP_T_LOAD, OP_TERM, OP_EMIT
    } dp_op_t;

    typedef enum logic [2:0] {
        A_EFF0, A_EFF1, A_EFF2, A_C1, A_C2, A_D
    } a_sel_t;

    typedef enum logic [2:0] {
        B_AMP1, B_AMP2, B_T0, B_T1, B_T2, B_CH, B_CHSQ, B_NI
    } b_sel_t;

    typedef struct packed {
        dp_op_t     op;
        a_sel_t     a_sel;
        b_sel_t     b_sel;
        logic       ha;
        logic       hb;
        logic [5:0] idx;
        logic       ln_model;
    } cmd_t;

    typedef struct packed {
        logic y_neg;
        logic y_big;
        logic zero_case;
        logic out_free;
        logic last;
    } status_t;

    function automatic logic [LN_STEPS:0][63:0] ln_coef_calc();
        logic [LN_STEPS:0][63:0] tab;
        logic [63:0]             s;
        logic [63:0]             t;
        tab = '0;
        for (int k = 1; k <= LN_STEPS; k++) begin
            s = '0;
            for (int n = 1; k * n < LN_FRAC; n++) begin
                t = (64'd1 << (LN_FRAC - k * n)) / 64'(n);
                if (n[0]) s = s + t;
                else s = s - t;
            end
            tab[k] = s;
        end
        return tab;
    endfunction

    function automatic logic [63:0] ln2_calc();
        logic [63:0] s;
        s = '0;
        for (int n = 1; n < LN_FRAC; n++) begin
            s = s + (64'd1 << (LN_FRAC - n)) / 64'(n);
        end
        return s;
    endfunction

    localparam logic [LN_STEPS:0][63:0] LN_COEF   = ln_coef_calc();
    localparam logic signed [63:0]      LN2_Q60   = ln2_calc();
    localparam logic signed [32:0]      LN2_Q32_S = 33'(LN2_Q60 >>> 28);

endpackage

FILE: hdl/pdacc_ifs.sv
interface pdacc_in_if;
    logic                valid;
    logic                ready;
    pdacc_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pdacc_out_if;
    logic                 valid;
    logic                 ready;
    pdacc_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/pdacc_regs.sv
module pdacc_regs (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [pdacc_pkg::CFG_ADDR_BITS-1:0]    paddr,
    input  logic [pdacc_pkg::CFG_DATA_BITS-1:0]    pwdata,
    output logic [pdacc_pkg::CFG_DATA_BITS-1:0]    prdata,
    output logic                                   pready,
    output pdacc_pkg::cfg_t                        cfg
);

    pdacc_pkg::cfg_t     cfg_reg;
    pdacc_pkg::reg_idx_t idx;
    logic                wr_en;

    assign idx    = pdacc_pkg::reg_idx_t'(paddr[pdacc_pkg::CFG_ADDR_BITS-1:3]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                pdacc_pkg::REG_BG_MODE:
                    cfg_reg.background_mode <= pdacc_pkg::bg_mode_t'(pwdata[1:0]);
                pdacc_pkg::REG_REL_MASK: cfg_reg.relative_mask <= pwdata[2:0];
                pdacc_pkg::REG_BG_C0: cfg_reg.bg_coeff_0 <= pwdata[pdacc_pkg::AMP_BITS-1:0];
                pdacc_pkg::REG_BG_C1: cfg_reg.bg_coeff_1 <= pwdata[pdacc_pkg::AMP_BITS-1:0];
                pdacc_pkg::REG_BG_C2: cfg_reg.bg_coeff_2 <= pwdata[pdacc_pkg::AMP_BITS-1:0];
                pdacc_pkg::REG_AMP0: cfg_reg.amplitude_0 <= pwdata[pdacc_pkg::AMP_BITS-1:0];
                pdacc_pkg::REG_AMP1: cfg_reg.amplitude_1 <= pwdata[pdacc_pkg::AMP_BITS-1:0];
                pdacc_pkg::REG_AMP2: cfg_reg.amplitude_2 <= pwdata[pdacc_pkg::AMP_BITS-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            pdacc_pkg::REG_BG_MODE:  prdata = 64'({cfg_reg.background_mode});
            pdacc_pkg::REG_REL_MASK: prdata = 64'({cfg_reg.relative_mask});
            pdacc_pkg::REG_BG_C0:    prdata = 64'({cfg_reg.bg_coeff_0});
            pdacc_pkg::REG_BG_C1:    prdata = 64'({cfg_reg.bg_coeff_1});
            pdacc_pkg::REG_BG_C2:    prdata = 64'({cfg_reg.bg_coeff_2});
            pdacc_pkg::REG_AMP0:     prdata = 64'({cfg_reg.amplitude_0});
            pdacc_pkg::REG_AMP1:     prdata = 64'({cfg_reg.amplitude_1});
            pdacc_pkg::REG_AMP2:     prdata = 64'({cfg_reg.amplitude_2});
        endcase
    end

endmodule

FILE: hdl/pdacc_ctrl.sv
module pdacc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    input  pdacc_pkg::status_t status,
    output logic               in_ready,
    output pdacc_pkg::cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_MODEL    = 6'b000010,
        ST_LN_OBS   = 6'b000100,
        ST_LN_MODEL = 6'b001000,
        ST_TERM     = 6'b010000,
        ST_DONE     = 6'b100000
    } state_t;

    localparam logic [6:0] MODEL_LAST = 7'd26;
    localparam logic [6:0] LN_LAST    = 7'd69;
    localparam logic [6:0] TERM_LAST  = 7'd4;

    state_t     state_reg, state_next;
    logic [6:0] step_reg, step_next;
    logic [6:0] off;

    assign in_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        cmd        = '{op: pdacc_pkg::OP_NOP, a_sel: pdacc_pkg::A_EFF0,
                       b_sel: pdacc_pkg::B_T0, ha: 1'b0, hb: 1'b0, idx: 6'd0,
                       ln_model: 1'b0};
        state_next = state_reg;
        step_next  = step_reg + 7'd1;
        off        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (in_fire) state_next = ST_MODEL;
            end
            ST_MODEL:
            begin
                case (step_reg) inside
                    7'd0, 7'd7: cmd.op = pdacc_pkg::OP_ACC_CLR;
                    [7'd1:7'd4]:
                    begin
                        off       = step_reg - 7'd1;
                        cmd.op    = pdacc_pkg::OP_MUL;
                        cmd.a_sel = pdacc_pkg::A_EFF0;
                        cmd.b_sel = pdacc_pkg::B_AMP1;
                        cmd.ha    = off[1];
                        cmd.hb    = off[0];
                    end
                    7'd6: cmd.op = pdacc_pkg::OP_SAVE_REL1;
                    [7'd8:7'd11]:
                    begin
                        off       = step_reg - 7'd8;
                        cmd.op    = pdacc_pkg::OP_MUL;
                        cmd.a_sel = pdacc_pkg::A_EFF0;
                        cmd.b_sel = pdacc_pkg::B_AMP2;
                        cmd.ha    = off[1];
                        cmd.hb    = off[0];
                    end
                    7'd13: cmd.op = pdacc_pkg::OP_SAVE_REL2;
                    7'd14: cmd.op = pdacc_pkg::OP_ACC_C0;
                    [7'd15:7'd24]:
                    begin
                        cmd.op = pdacc_pkg::OP_MUL;
                        cmd.ha = !step_reg[0];
                        case (step_reg) inside
                            [7'd15:7'd16]:
                            begin
                                cmd.a_sel = pdacc_pkg::A_EFF0;
                                cmd.b_sel = pdacc_pkg::B_T0;
                            end
                            [7'd17:7'd18]:
                            begin
                                cmd.a_sel = pdacc_pkg::A_EFF1;
                                cmd.b_sel = pdacc_pkg::B_T1;
                            end
                            [7'd19:7'd20]:
                            begin
                                cmd.a_sel = pdacc_pkg::A_EFF2;
                                cmd.b_sel = pdacc_pkg::B_T2;
                            end
                            [7'd21:7'd22]:
                            begin
                                cmd.a_sel = pdacc_pkg::A_C1;
                                cmd.b_sel = pdacc_pkg::B_CH;
                            end
                            default:
                            begin
                                cmd.a_sel = pdacc_pkg::A_C2;
                                cmd.b_sel = pdacc_pkg::B_CHSQ;
                            end
                        endcase
                    end
                    MODEL_LAST: cmd.op = pdacc_pkg::OP_CHECK_Y;
                    default: cmd.op = pdacc_pkg::OP_NOP;
                endcase
                if (step_reg == MODEL_LAST)
                begin
                    step_next = '0;
                    if (status.y_neg || status.y_big || status.zero_case)
                        state_next = ST_DONE;
                    else
                        state_next = ST_LN_OBS;
                end
            end
            ST_LN_OBS, ST_LN_MODEL:
            begin
                cmd.ln_model = (state_reg == ST_LN_MODEL);
                case (step_reg) inside
                    7'd0: cmd.op = pdacc_pkg::OP_LN_LOAD;
                    [7'd1:7'd6]:
                    begin
                        off     = step_reg - 7'd1;
                        cmd.op  = pdacc_pkg::OP_LN_NORM;
                        cmd.idx = off[5:0];
                    end
                    7'd7: cmd.op = pdacc_pkg::OP_LN_MANT;
                    [7'd8:7'd67]:
                    begin
                        off     = step_reg - 7'd7;
                        cmd.op  = pdacc_pkg::OP_LN_ITER;
                        cmd.idx = off[5:0];
                    end
                    7'd68: cmd.op = pdacc_pkg::OP_LN_FIN1;
                    default: cmd.op = pdacc_pkg::OP_LN_FIN2;
                endcase
                if (step_reg == LN_LAST)
                begin
                    step_next  = '0;
                    state_next = (state_reg == ST_LN_OBS) ? ST_LN_MODEL : ST_TERM;
                end
            end
            ST_TERM:
            begin
                cmd.a_sel = pdacc_pkg::A_D;
                cmd.b_sel = pdacc_pkg::B_NI;
                case (step_reg) inside
                    7'd0: cmd.op = pdacc_pkg::OP_T_LOAD;
                    [7'd1:7'd2]:
                    begin
                        cmd.op = pdacc_pkg::OP_MUL;
                        cmd.ha = step_reg[1];
                    end
                    TERM_LAST: cmd.op = pdacc_pkg::OP_TERM;
                    default: cmd.op = pdacc_pkg::OP_NOP;
                endcase
                if (step_reg == TERM_LAST)
                begin
                    step_next  = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                step_next = '0;
                if (!status.last)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.op     = pdacc_pkg::OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

endmodule

FILE: hdl/pdacc_dp.sv
module pdacc_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pdacc_pkg::cfg_t      cfg,
    input  logic                 in_fire,
    input  pdacc_pkg::in_item_t  in_data,
    input  pdacc_pkg::cmd_t      cmd,
    output pdacc_pkg::status_t   status,
    input  logic                 results_ready,
    output logic                 out_valid,
    output pdacc_pkg::out_item_t out_data
);

    localparam int CHSQ_BITS = 2 * pdacc_pkg::CHANNEL_BITS;

    pdacc_pkg::in_item_t  in_reg;
    logic [CHSQ_BITS-1:0] chsq_reg;
    logic signed [63:0]   rel1_reg, rel2_reg;
    logic signed [127:0]  acc_reg;
    logic [63:0]          pp_reg;
    logic [1:0]           pp_shift_reg;
    logic                 pp_neg_reg;
    logic                 pp_vld_reg;
    logic [62:0]          yq_reg;
    logic [63:0]          ln_x_reg;
    logic [5:0]           ln_e_reg;
    logic [61:0]          ln_m_reg;
    logic signed [63:0]   ln_acc_reg;
    logic [63:0]          lnm_reg;
    logic signed [63:0]   ln_n_reg;
    logic signed [63:0]   d_reg;
    logic [pdacc_pkg::SUM_BITS-1:0] sum_reg;
    logic                 neg_seen_reg;
    logic                 sat_seen_reg;
    logic                 out_valid_reg;
    pdacc_pkg::out_item_t out_data_reg;

    logic signed [63:0]   a_val, b_val;
    logic [63:0]          a_mag, b_mag;
    logic [31:0]          a_half, b_half;
    logic [63:0]          pp_next;
    logic [127:0]         pp_wide;
    logic [6:0]           pp_sh;
    logic                 bg_lin_on, bg_quad_on;
    logic [6:0]           norm_sh;
    logic [63:0]          hi_mask;
    logic [62:0]          ln_t;
    logic signed [7:0]    ln_pow;
    logic signed [40:0]   ln_prod;
    logic signed [63:0]   ln_res;
    logic [63:0]          lnm_next;
    logic [63:0]          term_val;
    logic                 term_bad;
    logic [63:0]          sum_new;
    logic                 sum_over;
    logic                 y_big;
    logic                 zero_case;
    logic                 emit;

    assign bg_lin_on  = (cfg.background_mode == pdacc_pkg::BG_QUAD)
                     || (cfg.background_mode == pdacc_pkg::BG_LIN);
    assign bg_quad_on = (cfg.background_mode == pdacc_pkg::BG_QUAD);

    always_comb
    begin
        case (cmd.a_sel)
            pdacc_pkg::A_EFF0: a_val = 64'(cfg.amplitude_0);
            pdacc_pkg::A_EFF1:
                a_val = (cfg.relative_mask[1] && pdacc_pkg::NUM_TEMPLATES > 1)
                      ? rel1_reg : 64'(cfg.amplitude_1);
            pdacc_pkg::A_EFF2:
                a_val = (cfg.relative_mask[2] && pdacc_pkg::NUM_TEMPLATES > 2)
                      ? rel2_reg : 64'(cfg.amplitude_2);
            pdacc_pkg::A_C1:   a_val = 64'(cfg.bg_coeff_1);
            pdacc_pkg::A_C2:   a_val = 64'(cfg.bg_coeff_2);
            pdacc_pkg::A_D:    a_val = d_reg;
            default:           a_val = '0;
        endcase
        case (cmd.b_sel)
            pdacc_pkg::B_AMP1: b_val = 64'(cfg.amplitude_1);
            pdacc_pkg::B_AMP2: b_val = 64'(cfg.amplitude_2);
            pdacc_pkg::B_T0:   b_val = 64'(in_reg.template_count_0);
            pdacc_pkg::B_T1:
                b_val = (pdacc_pkg::NUM_TEMPLATES > 1) ? 64'(in_reg.template_count_1) : '0;
            pdacc_pkg::B_T2:
                b_val = (pdacc_pkg::NUM_TEMPLATES > 2) ? 64'(in_reg.template_count_2) : '0;
            pdacc_pkg::B_CH:   b_val = bg_lin_on ? 64'(in_reg.channel) : '0;
            pdacc_pkg::B_CHSQ: b_val = bg_quad_on ? 64'(chsq_reg) : '0;
            pdacc_pkg::B_NI:   b_val = 64'(in_reg.observed_count);
            default:           b_val = '0;
        endcase
        a_mag   = a_val[63] ? (~a_val + 64'd1) : a_val;
        b_mag   = b_val[63] ? (~b_val + 64'd1) : b_val;
        a_half  = cmd.ha ? a_mag[63:32] : a_mag[31:0];
        b_half  = cmd.hb ? b_mag[63:32] : b_mag[31:0];
        pp_next = a_half * b_half;
    end

    always_comb
    begin
        pp_sh   = {pp_shift_reg, 5'b0};
        pp_wide = 128'(pp_reg) << pp_sh;
        if (pp_neg_reg) pp_wide = ~pp_wide + 128'd1;
    end

    always_comb
    begin
        norm_sh  = 7'd32 >> cmd.idx[2:0];
        hi_mask  = ~({64{1'b1}} >> norm_sh);
        ln_t     = {1'b0, ln_m_reg} + 63'(ln_m_reg >> cmd.idx);
        lnm_next = (pdacc_pkg::LN2_Q60 > ln_acc_reg)
                 ? 64'(pdacc_pkg::LN2_Q60 - ln_acc_reg) : 64'd0;
        ln_pow   = $signed({2'b00, ln_e_reg}) - (cmd.ln_model ? 8'sd16 : 8'sd0);
        ln_prod  = ln_pow * pdacc_pkg::LN2_Q32_S;
        ln_res   = 64'(ln_prod) + 64'($signed({1'b0, lnm_reg[63:28]}));
    end

    assign y_big     = |acc_reg[126:79];
    assign zero_case = (in_reg.observed_count == '0) || (acc_reg[78:16] == '0);

    always_comb
    begin
        term_val = '0;
        term_bad = 1'b0;
        if (cmd.op == pdacc_pkg::OP_CHECK_Y)
        begin
            term_val = {1'b0, acc_reg[78:16]};
        end
        else if (acc_reg[127])
        begin
            term_val = '0;
        end
        else if (|acc_reg[126:78])
        begin
            term_bad = 1'b1;
        end
        else
        begin
            term_val = 64'(acc_reg[77:16]);
        end
        if (term_val > pdacc_pkg::DEV_LIMIT) term_bad = 1'b1;
        sum_new  = 64'(sum_reg) + term_val;
        sum_over = sum_new > pdacc_pkg::DEV_LIMIT;
    end

    assign emit = (cmd.op == pdacc_pkg::OP_EMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            neg_seen_reg  <= 1'b0;
            sat_seen_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pp_vld_reg    <= 1'b0;
        end
        else
        begin
            pp_vld_reg <= (cmd.op == pdacc_pkg::OP_MUL);
            if (emit)
                out_valid_reg <= 1'b1;
            else if (results_ready)
                out_valid_reg <= 1'b0;
            if (emit)
            begin
                sum_reg      <= '0;
                neg_seen_reg <= 1'b0;
                sat_seen_reg <= 1'b0;
            end
            else if ((cmd.op == pdacc_pkg::OP_CHECK_Y) && acc_reg[127])
            begin
                neg_seen_reg <= 1'b1;
            end
            else if ((cmd.op == pdacc_pkg::OP_CHECK_Y) && y_big)
            begin
                sat_seen_reg <= 1'b1;
            end
            else if (((cmd.op == pdacc_pkg::OP_CHECK_Y) && zero_case)
                     || (cmd.op == pdacc_pkg::OP_TERM))
            begin
                if (term_bad || sum_over)
                begin
                    sat_seen_reg <= 1'b1;
                    sum_reg      <= pdacc_pkg::DEV_LIMIT[pdacc_pkg::SUM_BITS-1:0];
                end
                else
                begin
                    sum_reg <= sum_new[pdacc_pkg::SUM_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire) in_reg <= in_data;
        chsq_reg <= CHSQ_BITS'(in_reg.channel) * CHSQ_BITS'(in_reg.channel);
        if (cmd.op == pdacc_pkg::OP_MUL)
        begin
            pp_reg       <= pp_next;
            pp_shift_reg <= 2'(cmd.ha) + 2'(cmd.hb);
            pp_neg_reg   <= a_val[63] ^ b_val[63];
        end
        case (cmd.op)
            pdacc_pkg::OP_ACC_CLR: acc_reg <= '0;
            pdacc_pkg::OP_ACC_C0:
                acc_reg <= (cfg.background_mode != pdacc_pkg::BG_NONE)
                         ? 128'(cfg.bg_coeff_0) : '0;
            pdacc_pkg::OP_T_LOAD:
                acc_reg <= (128'(yq_reg) << 16) - (128'(in_reg.observed_count) << 32);
            default:
                if (pp_vld_reg) acc_reg <= acc_reg + pp_wide;
        endcase
        case (cmd.op)
            pdacc_pkg::OP_SAVE_REL1: rel1_reg <= acc_reg[95:32];
            pdacc_pkg::OP_SAVE_REL2: rel2_reg <= acc_reg[95:32];
            pdacc_pkg::OP_CHECK_Y:   yq_reg <= acc_reg[78:16];
            pdacc_pkg::OP_LN_LOAD:
            begin
                ln_x_reg <= cmd.ln_model ? {1'b0, yq_reg} : 64'(in_reg.observed_count);
                ln_e_reg <= 6'd63;
            end
            pdacc_pkg::OP_LN_NORM:
            begin
                if ((ln_x_reg & hi_mask) == '0)
                begin
                    ln_x_reg <= ln_x_reg << norm_sh;
                    ln_e_reg <= ln_e_reg - norm_sh[5:0];
                end
            end
            pdacc_pkg::OP_LN_MANT:
            begin
                ln_m_reg   <= {1'b0, ln_x_reg[63:3]};
                ln_acc_reg <= '0;
            end
            pdacc_pkg::OP_LN_ITER:
            begin
                if (ln_t <= (63'd1 << 61))
                begin
                    ln_m_reg   <= ln_t[61:0];
                    ln_acc_reg <= ln_acc_reg + $signed(pdacc_pkg::LN_COEF[cmd.idx]);
                end
            end
            pdacc_pkg::OP_LN_FIN1: lnm_reg <= lnm_next;
            pdacc_pkg::OP_LN_FIN2:
            begin
                if (cmd.ln_model) d_reg <= ln_n_reg - ln_res;
                else ln_n_reg <= ln_res;
            end
            default: ;
        endcase
        if (emit)
        begin
            out_data_reg.deviance       <= (neg_seen_reg || sat_seen_reg)
                                         ? pdacc_pkg::DEV_FULL : {sum_reg, 1'b0};
            out_data_reg.model_negative <= neg_seen_reg;
            out_data_reg.overflowed     <= sat_seen_reg;
        end
    end

    assign status.y_neg     = acc_reg[127];
    assign status.y_big     = y_big;
    assign status.zero_case = zero_case;
    assign status.out_free  = !out_valid_reg || results_ready;
    assign status.last      = in_reg.last_channel;
    assign out_valid        = out_valid_reg;
    assign out_data         = out_data_reg;

    a_acc_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
        pp_vld_reg |-> (cmd.op != pdacc_pkg::OP_ACC_CLR && cmd.op != pdacc_pkg::OP_ACC_C0
            && cmd.op != pdacc_pkg::OP_T_LOAD && cmd.op != pdacc_pkg::OP_CHECK_Y
            && cmd.op != pdacc_pkg::OP_TERM && cmd.op != pdacc_pkg::OP_SAVE_REL1
            && cmd.op != pdacc_pkg::OP_SAVE_REL2))
        else $error("partial product lands on an accumulator load or read");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!out_valid_reg || results_ready))
        else $error("result emitted over a pending result");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (sum_reg == '0 && !neg_seen_reg && !sat_seen_reg && out_valid_reg))
        else $error("accumulator not restarted after a result");

    a_even_dev: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.model_negative && !out_data_reg.overflowed)
            |-> !out_data_reg.deviance[0])
        else $error("unsaturated deviance is not twice the sum");

endmodule

FILE: hdl/poisson_deviance_accumulator_top.sv
// Channel   Direction  Handshake      Payload
// items     in         valid/ready    channel, observed_count, template counts, last_channel
// results   out        valid/ready    deviance, model_negative, overflowed
// apb       in         psel/penable   registers at byte address 8*i, 64-bit data
//
// An item takes the long path from acceptance to the next acceptance when a logarithm term
// is needed, and a short path when the model is negative, too large, or it or the count is zero.
// The long path is set by the 60-step shift-and-add logarithm, run twice on one unit.
// Reset clears the configuration, the running sum and the flags, and leaves no result pending.
// A result waits in its output register; a further last channel waits until it is taken.
module poisson_deviance_accumulator_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pdacc_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [pdacc_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [pdacc_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                                pready,
    pdacc_in_if.sink                            items,
    pdacc_out_if.source                         results
);

    pdacc_pkg::cfg_t    cfg;
    pdacc_pkg::cmd_t    cmd;
    pdacc_pkg::status_t status;
    logic               in_ready;
    logic               in_fire;

    assign items.ready = in_ready;
    assign in_fire     = items.valid && in_ready;

    pdacc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pdacc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    pdacc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_fire       (in_fire),
        .in_data       (items.data),
        .cmd           (cmd),
        .status        (status),
        .results_ready (results.ready),
        .out_valid     (results.valid),
        .out_data      (results.data)
    );

endmodule

FILE: sim/tb_poisson_deviance_accumulator_top.sv
module tb_poisson_deviance_accumulator_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4000;
    localparam int ITEM_TARGET = 1200;
    localparam int SETTLE_CYCLES = 200;

    class deviance_scoreboard;
        pdacc_pkg::out_item_t pending_results[$];
        int          errors;
        bit [1:0]    bg_mode;
        bit [2:0]    rel_mask;
        logic signed [pdacc_pkg::AMP_BITS-1:0] coeff [3];
        logic signed [pdacc_pkg::AMP_BITS-1:0] amp [3];
        bit [63:0]   dev_sum;
        bit          neg_flag;
        bit          sat_flag;
        longint      step_ln [pdacc_pkg::LN_STEPS+1];
        longint      ln2_fix;

        function new();
            longint s;
            errors = 0;
            bg_mode = pdacc_pkg::BG_NONE;
            rel_mask = '0;
            for (int i = 0; i < 3; i++)
            begin
                coeff[i] = '0;
                amp[i] = '0;
            end
            dev_sum = '0;
            neg_flag = 0;
            sat_flag = 0;
            ln2_fix = 0;
            for (int n = 1; n < 60; n++)
                ln2_fix += longint'((64'd1 << (60 - n)) / 64'(n));
            for (int k = 1; k <= pdacc_pkg::LN_STEPS; k++)
            begin
                s = 0;
                for (int n = 1; k * n < 60; n++)
                begin
                    if (n % 2 == 1)
                        s += longint'((64'd1 << (60 - k * n)) / 64'(n));
                    else
                        s -= longint'((64'd1 << (60 - k * n)) / 64'(n));
                end
                step_ln[k] = s;
            end
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $realtime);
        endtask

        function void write_reg(pdacc_pkg::reg_idx_t r, bit [63:0] v);
            case (r)
                pdacc_pkg::REG_BG_MODE:  bg_mode = v[1:0];
                pdacc_pkg::REG_REL_MASK: rel_mask = v[2:0];
                pdacc_pkg::REG_BG_C0:    coeff[0] = v[pdacc_pkg::AMP_BITS-1:0];
                pdacc_pkg::REG_BG_C1:    coeff[1] = v[pdacc_pkg::AMP_BITS-1:0];
                pdacc_pkg::REG_BG_C2:    coeff[2] = v[pdacc_pkg::AMP_BITS-1:0];
                pdacc_pkg::REG_AMP0:     amp[0] = v[pdacc_pkg::AMP_BITS-1:0];
                pdacc_pkg::REG_AMP1:     amp[1] = v[pdacc_pkg::AMP_BITS-1:0];
                pdacc_pkg::REG_AMP2:     amp[2] = v[pdacc_pkg::AMP_BITS-1:0];
                default:      ;
            endcase
        endfunction

        function longint log_fix(bit [63:0] x, int frac);
            int     p;
            bit [63:0] y;
            bit [63:0] t;
            longint acc;
            longint lnm;
            p = 63;
            while (p > 0 && !x[p])
                p--;
            y = (p <= 60) ? (x << (60 - p)) : (x >> (p - 60));
            acc = 0;
            for (int k = 1; k <= pdacc_pkg::LN_STEPS; k++)
            begin
                t = y + (y >> k);
                if (t <= (64'd1 << 61))
                begin
                    y = t;
                    acc += step_ln[k];
                end
            end
            lnm = (ln2_fix > acc) ? (ln2_fix - acc) : 0;
            return longint'(p - frac) * (ln2_fix >>> 28) + (lnm >>> 28);
        endfunction

        function void note_item(pdacc_pkg::in_item_t it);
            logic signed [127:0] model;
            logic signed [127:0] a0w;
            logic signed [127:0] ajw;
            logic signed [127:0] effw;
            logic signed [127:0] cw;
            logic signed [127:0] prod;
            logic signed [127:0] niw;
            logic signed [127:0] dw;
            logic signed [127:0] tw;
            logic signed [63:0]  e64;
            bit [23:0]  tc [3];
            bit [63:0]  yq;
            bit [63:0]  term;
            bit [63:0]  s;
            bit         bad;
            longint     d;
            pdacc_pkg::out_item_t r;
            tc[0] = it.template_count_0;
            tc[1] = it.template_count_1;
            tc[2] = it.template_count_2;
            model = '0;
            a0w = 128'(amp[0]);
            for (int j = 0; j < pdacc_pkg::NUM_TEMPLATES; j++)
            begin
                ajw = 128'(amp[j]);
                effw = ajw;
                if (j >= 1 && rel_mask[j])
                begin
                    prod = a0w * ajw;
                    e64 = prod[95:32];
                    effw = 128'(e64);
                end
                cw = '0;
                cw[23:0] = tc[j];
                model = model + effw * cw;
            end
            if (bg_mode != pdacc_pkg::BG_NONE)
            begin
                effw = 128'(coeff[0]);
                model = model + effw;
                cw = '0;
                cw[14:0] = it.channel;
                if (bg_mode == pdacc_pkg::BG_QUAD || bg_mode == pdacc_pkg::BG_LIN)
                begin
                    effw = 128'(coeff[1]);
                    model = model + effw * cw;
                end
                if (bg_mode == pdacc_pkg::BG_QUAD)
                begin
                    effw = 128'(coeff[2]);
                    model = model + effw * (cw * cw);
                end
            end

            if (model < 0)
                neg_flag = 1;
            else if (model[127:79] != '0)
                sat_flag = 1;
            else
            begin
                yq = model[79:16];
                term = yq;
                bad = 0;
                if (it.observed_count != 0 && yq != 0)
                begin
                    d = log_fix(64'(it.observed_count), 0) - log_fix(yq, 16);
                    niw = '0;
                    niw[23:0] = it.observed_count;
                    dw = 128'(d);
                    cw = '0;
                    cw[63:0] = yq;
                    tw = (cw <<< 16) - (niw <<< 32) + niw * dw;
                    if (tw < 0)
                        term = 0;
                    else if (tw[127:78] != '0)
                        bad = 1;
                    else
                        term = tw[79:16];
                end
                if (!bad && term > pdacc_pkg::DEV_LIMIT)
                    bad = 1;
                if (bad)
                begin
                    sat_flag = 1;
                    dev_sum = pdacc_pkg::DEV_LIMIT;
                end
                else
                begin
                    s = dev_sum + term;
                    if (s > pdacc_pkg::DEV_LIMIT)
                    begin
                        sat_flag = 1;
                        s = pdacc_pkg::DEV_LIMIT;
                    end
                    dev_sum = s;
                end
            end

            if (it.last_channel)
            begin
                r.deviance = (neg_flag || sat_flag) ? pdacc_pkg::DEV_FULL
                                                    : pdacc_pkg::DEV_BITS'(dev_sum << 1);
                r.model_negative = neg_flag;
                r.overflowed = sat_flag;
                pending_results.push_back(r);
                dev_sum = '0;
                neg_flag = 0;
                sat_flag = 0;
            end
        endfunction

        task check_result(pdacc_pkg::out_item_t got);
            pdacc_pkg::out_item_t want;
            if (pending_results.size() == 0)
            begin
                report("unexpected result", 64'(got), 64'd0);
                return;
            end
            want = pending_results.pop_front();
            if (got.deviance !== want.deviance)
                report("deviance", 64'(got.deviance), 64'(want.deviance));
            if (got.model_negative !== want.model_negative)
                report("model_negative", 64'(got.model_negative), 64'(want.model_negative));
            if (got.overflowed !== want.overflowed)
                report("overflowed", 64'(got.overflowed), 64'(want.overflowed));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [pdacc_pkg::CFG_ADDR_BITS-1:0] paddr;
    logic [pdacc_pkg::CFG_DATA_BITS-1:0] pwdata;
    logic [pdacc_pkg::CFG_DATA_BITS-1:0] prdata;
    logic pready;

    pdacc_in_if  items ();
    pdacc_out_if results ();

    poisson_deviance_accumulator_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .items   (items),
        .results (results)
    );

    deviance_scoreboard sb;
    int idle_cycles = 0;
    int burst_left;
    int ready_mode;
    int ready_left = 0;
    int channels_sent;

    initial
    begin
        clk = 0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((items.valid && items.ready) || (results.valid && results.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (items.valid && items.ready)
                sb.note_item(items.data);
            if (results.valid && results.ready)
                sb.check_result(results.data);
            if (idle_cycles > STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(1, 400);
        end
        ready_left--;
        case (ready_mode)
            0: results.ready <= 1'b1;
            1: results.ready <= 1'($urandom_range(0, 1));
            2: results.ready <= ($urandom_range(0, 7) == 0);
            default: results.ready <= 1'b0;
        endcase
    end

    task automatic write_reg(pdacc_pkg::reg_idx_t r, bit [63:0] v);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 3'b000};
        pwdata <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.write_reg(r, v);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_channel(pdacc_pkg::in_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0)
            begin
                @(negedge clk);
                items.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        items.valid <= 1'b1;
        items.data <= it;
        @(posedge clk);
        while (!items.ready)
            @(posedge clk);
        channels_sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        items.valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic pdacc_pkg::in_item_t make_channel(int ch, int ni, int t0, int t1,
                                                         int t2, bit last);
        pdacc_pkg::in_item_t it;
        it.channel = pdacc_pkg::CHANNEL_BITS'(ch);
        it.observed_count = pdacc_pkg::COUNT_BITS'(ni);
        it.template_count_0 = pdacc_pkg::COUNT_BITS'(t0);
        it.template_count_1 = pdacc_pkg::COUNT_BITS'(t1);
        it.template_count_2 = pdacc_pkg::COUNT_BITS'(t2);
        it.last_channel = last;
        return it;
    endfunction

    function automatic bit [23:0] rand_count();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 24'hFF_FFFF;
            2: return 24'($urandom);
            default: return 24'($urandom_range(0, 2000));
        endcase
    endfunction

    function automatic bit [63:0] rand_coeff(bit near_unit);
        bit [63:0] v;
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = {$urandom, $urandom};
            2: v = 64'h0000_7FFF_FFFF_FFFF;
            3: v = 64'hFFFF_8000_0000_0000;
            4: v = -(64'($urandom) << $urandom_range(0, 4));
            default:
            begin
                if (near_unit)
                    v = (64'd1 << 32) + 64'($urandom_range(0, 32'h3FFF_FFFF))
                        - 64'd536870912;
                else
                    v = 64'($urandom) << $urandom_range(0, 3);
            end
        endcase
        return v;
    endfunction

    task automatic random_setting();
        write_reg(pdacc_pkg::REG_BG_MODE, {$urandom, $urandom});
        write_reg(pdacc_pkg::REG_REL_MASK, {$urandom, $urandom});
        write_reg(pdacc_pkg::REG_BG_C0, rand_coeff(1'b0));
        write_reg(pdacc_pkg::REG_BG_C1, rand_coeff(1'b0));
        write_reg(pdacc_pkg::REG_BG_C2, rand_coeff(1'b0) >> $urandom_range(0, 20));
        write_reg(pdacc_pkg::REG_AMP0, rand_coeff(1'b1));
        write_reg(pdacc_pkg::REG_AMP1, rand_coeff(1'b1));
        write_reg(pdacc_pkg::REG_AMP2, rand_coeff(1'b1));
    endtask

    initial
    begin
        int spectrum_len;
        int phase_items;
        bit last;
        sb = new();
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        items.valid = 1'b0;
        items.data = '0;
        burst_left = 0;
        channels_sent = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: the model is zero, so every term is zero.
        send_channel(make_channel(0, 0, 0, 0, 0, 1'b0));
        send_channel(make_channel(32767, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF,
                                  1'b1));
        drain_results();

        write_reg(pdacc_pkg::REG_AMP0, 64'h1_0000_0000);
        write_reg(pdacc_pkg::REG_AMP1, 64'h0_8000_0000);
        write_reg(pdacc_pkg::REG_AMP2, 64'h2_0000_0000);
        write_reg(pdacc_pkg::REG_REL_MASK, 64'd7);
        write_reg(pdacc_pkg::REG_BG_MODE, 64'(pdacc_pkg::BG_CONST));
        write_reg(pdacc_pkg::REG_BG_C0, 64'h3_0000_0000);
        send_channel(make_channel(5, 10, 7, 3, 1, 1'b0));
        send_channel(make_channel(6, 0, 7, 3, 1, 1'b0));
        send_channel(make_channel(7, 24'hFF_FFFF, 1, 1, 1, 1'b0));
        send_channel(make_channel(8, 1, 0, 0, 0, 1'b1));
        drain_results();

        write_reg(pdacc_pkg::REG_BG_MODE, 64'(pdacc_pkg::BG_QUAD));
        write_reg(pdacc_pkg::REG_BG_C0, 64'h0);
        write_reg(pdacc_pkg::REG_BG_C1, 64'h0000_0000_0001_0000);
        write_reg(pdacc_pkg::REG_BG_C2, 64'hFFFF_FFFF_FFFF_FF00);
        send_channel(make_channel(0, 3, 0, 0, 0, 1'b0));
        send_channel(make_channel(32767, 3, 0, 0, 0, 1'b1));
        drain_results();
        write_reg(pdacc_pkg::REG_BG_MODE, 64'(pdacc_pkg::BG_LIN));
        write_reg(pdacc_pkg::REG_AMP0, 64'h0000_7FFF_FFFF_FFFF);
        write_reg(pdacc_pkg::REG_REL_MASK, 64'd0);
        send_channel(make_channel(100, 50, 24'hFF_FFFF, 0, 0, 1'b1));
        drain_results();

        write_reg(pdacc_pkg::REG_AMP0, 64'hFFFF_8000_0000_0000);
        write_reg(pdacc_pkg::REG_BG_MODE, 64'(pdacc_pkg::BG_NONE));
        send_channel(make_channel(1, 4, 2, 0, 0, 1'b0));
        send_channel(make_channel(2, 4, 0, 0, 0, 1'b1));
        drain_results();
        write_reg(pdacc_pkg::REG_AMP0, 64'h0000_0000_0000_0001);
        send_channel(make_channel(3, 9, 1, 0, 0, 1'b1));
        drain_results();

        while (channels_sent < ITEM_TARGET)
        begin
            random_setting();
            phase_items = 0;
            while (phase_items < 100)
            begin
                spectrum_len = $urandom_range(1, 12);
                for (int i = 0; i < spectrum_len; i++)
                begin
                    last = (i == spectrum_len - 1) || ($urandom_range(0, 15) == 0);
                    send_channel(make_channel($urandom_range(0, 32767) >> $urandom_range(0, 8),
                                              rand_count(), rand_count(), rand_count(),
                                              rand_count(), last));
                    phase_items++;
                end
            end
            drain_results();
        end

        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
